// ===== sv/mte_pkg.sv =====
// Package for the Morse text encoder: symbol codes, character constants,
// code table and the segment builder used by the front end.
// No dependencies.
`default_nettype none

package mte_pkg;

  localparam int MAX_CODE_SYMBOLS = 6;

  localparam int CHAR_W   = 8;
  localparam int CODE_W   = 6;  // widest raw code ('!' has six symbols)
  localparam int CLEN_W   = 3;

  // One encoded character: code symbols plus an optional separator.
  localparam int SEG_MAX    = MAX_CODE_SYMBOLS + 1;
  localparam int SEG_LEN_W  = $clog2(SEG_MAX + 1);
  localparam int SEG_IDX_W  = $clog2(SEG_MAX);
  // One input item: held character followed by the flushed one.
  localparam int SEQ_MAX    = 2 * SEG_MAX;
  localparam int SEQ_W      = 2 * SEQ_MAX;
  localparam int CNT_W      = $clog2(SEQ_MAX + 1);

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_BANG  = 8'h21;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;

  typedef enum logic [1:0] {
    SYM_DOT   = 2'd0,
    SYM_DASH  = 2'd1,
    SYM_GAP   = 2'd2,
    SYM_SLASH = 2'd3
  } sym_t;

  typedef struct packed {
    logic [CLEN_W-1:0] len;
    logic [CODE_W-1:0] bits;   // first symbol in highest used bit, 1 = dash
  } code_t;

  typedef struct packed {
    sym_t [SEG_MAX-1:0]   syms;  // element 0 goes out first
    logic [SEG_LEN_W-1:0] len;
  } seg_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;       // symbol 0 in bits [1:0]
    logic [CNT_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_status_t;

  localparam code_t LETTER_CODES [0:25] = '{
    '{3'd2, 6'd1},  '{3'd4, 6'd8},  '{3'd4, 6'd10}, '{3'd3, 6'd4},
    '{3'd1, 6'd0},  '{3'd4, 6'd2},  '{3'd3, 6'd6},  '{3'd4, 6'd0},
    '{3'd2, 6'd0},  '{3'd4, 6'd7},  '{3'd3, 6'd5},  '{3'd4, 6'd4},
    '{3'd2, 6'd3},  '{3'd2, 6'd2},  '{3'd3, 6'd7},  '{3'd4, 6'd6},
    '{3'd4, 6'd13}, '{3'd3, 6'd2},  '{3'd3, 6'd0},  '{3'd1, 6'd1},
    '{3'd3, 6'd1},  '{3'd4, 6'd1},  '{3'd3, 6'd3},  '{3'd4, 6'd9},
    '{3'd4, 6'd11}, '{3'd4, 6'd12}
  };

  localparam code_t DIGIT_CODES [0:9] = '{
    '{3'd5, 6'd31}, '{3'd5, 6'd15}, '{3'd5, 6'd7},  '{3'd5, 6'd3},
    '{3'd5, 6'd1},  '{3'd5, 6'd0},  '{3'd5, 6'd16}, '{3'd5, 6'd24},
    '{3'd5, 6'd28}, '{3'd5, 6'd30}
  };

  localparam code_t BANG_CODE = '{3'd6, 6'd43};

  function automatic code_t code_lookup(input logic [CHAR_W-1:0] c);
    code_t k;
    k = '0;
    if (c >= CHAR_A && c <= CHAR_Z) begin
      k = LETTER_CODES[5'(c - CHAR_A)];
    end else if (c >= CHAR_0 && c <= CHAR_9) begin
      k = DIGIT_CODES[4'(c - CHAR_0)];
    end else if (c == CHAR_BANG) begin
      k = BANG_CODE;
    end
    return k;
  endfunction

  // Symbols for one character; the separator depends on what follows it.
  function automatic seg_t seg_build(input logic [CHAR_W-1:0] c,
                                     input logic next_space,
                                     input logic at_end);
    seg_t                 s;
    code_t                k;
    logic [SEG_LEN_W-1:0] n;
    logic [CODE_W-1:0]    t;
    s.syms = {SEG_MAX{SYM_DOT}};
    s.len  = '0;
    k      = code_lookup(c);
    t      = '0;
    n = (SEG_LEN_W'(k.len) > SEG_LEN_W'(MAX_CODE_SYMBOLS)) ?
        SEG_LEN_W'(MAX_CODE_SYMBOLS) : SEG_LEN_W'(k.len);
    if (c == CHAR_SPACE) begin
      s.syms[0] = SYM_SLASH;
      s.len     = SEG_LEN_W'(1);
    end else if (k.len != '0) begin
      for (int i = 0; i < MAX_CODE_SYMBOLS; i++) begin
        if (SEG_LEN_W'(i) < n) begin
          t = k.bits >> (int'(k.len) - 1 - i);
          s.syms[i] = t[0] ? SYM_DASH : SYM_DOT;
        end
      end
      if (at_end) begin
        s.syms[n[SEG_IDX_W-1:0]] = SYM_SLASH;
        s.len = n + SEG_LEN_W'(1);
      end else if (!next_space) begin
        s.syms[n[SEG_IDX_W-1:0]] = SYM_GAP;
        s.len = n + SEG_LEN_W'(1);
      end else begin
        s.len = n;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mte_if.sv =====
// Channel interfaces of the Morse text encoder: character input and
// symbol output, valid/ready with payload. Depends on mte_pkg.
`default_nettype none

interface mte_in_if import mte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              end_of_message;

  modport source (output valid, output character, output end_of_message,
                  input ready);
  modport sink   (input valid, input character, input end_of_message,
                  output ready);
endinterface

interface mte_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] symbol;
  logic       run_last;

  modport source (output valid, output symbol, output run_last, input ready);
  modport sink   (input valid, input symbol, input run_last, output ready);
endinterface

`default_nettype wire

// ===== sv/morse_text_encoder.sv =====
// Top level of the Morse text encoder: front end, sequence queue, back end.
// Depends on mte_pkg, mte_if, mte_front, mte_queue, mte_back.
//
//   channel  dir  payload                            transfer when
//   in_ch    in   character[7:0], end_of_message     valid && ready
//   out_ch   out  symbol[1:0], run_last              valid && ready
//
// One symbol leaves per cycle while out_ch is ready and a run is loaded; an
// item causes 0 to 14 symbols, so the output shifter sets the sustained rate.
// Input is taken every cycle while the two-entry queue has room.
// Synchronous active-low reset; drops the held character.
// Either side may stall; the queue decouples front and back.
`default_nettype none

module morse_text_encoder import mte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mte_in_if.sink    in_ch,
  mte_out_if.source out_ch
);

  q_status_t q_stat;
  logic      q_push;
  logic      q_pop;
  entry_t    q_in;
  entry_t    q_head;

  mte_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  mte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  mte_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_ch.ready)
    else $error("input ready while queue full");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.run_last) |=> out_ch.valid)
    else $error("symbol run broken before its last symbol");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_ch.valid && !q_stat.avail))
    else $error("output or queue not idle after reset");

endmodule

`default_nettype wire

// ===== sv/mte_front.sv =====
// Front end: holds the pending character, turns each accepted item into at
// most one packed symbol sequence for the queue. Depends on mte_pkg, mte_if.
`default_nettype none

module mte_front import mte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mte_in_if.sink     in_ch,
  input  q_status_t  q_stat,
  output logic       q_push,
  output entry_t     q_entry
);

  logic [CHAR_W-1:0] held_char_r, held_char_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic              in_xfer;
  seg_t              seg_a, seg_b;

  assign in_ch.ready = !q_stat.full;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    seg_a = '0;
    seg_b = '0;
    if (held_valid_r) begin
      seg_a = seg_build(held_char_r, in_ch.character == CHAR_SPACE, 1'b0);
    end
    if (in_ch.end_of_message) begin
      seg_b = seg_build(in_ch.character, 1'b0, 1'b1);
    end
    // second segment lands right after the first one's symbols
    q_entry.seq = SEQ_W'(seg_a.syms) | (SEQ_W'(seg_b.syms) << {seg_a.len, 1'b0});
    q_entry.len = CNT_W'(seg_a.len) + CNT_W'(seg_b.len);
  end

  assign q_push = in_xfer && (q_entry.len != '0);

  always_comb begin
    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    if (in_xfer) begin
      held_char_nxt  = in_ch.end_of_message ? '0 : in_ch.character;
      held_valid_nxt = !in_ch.end_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r  <= '0;
      held_valid_r <= 1'b0;
    end else begin
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mte_queue.sv =====
// Short FIFO of symbol sequences between front and back.
// Depends on mte_pkg.
`default_nettype none

module mte_queue import mte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  entry_t     push_entry,
  input  logic       pop,
  output entry_t     head,
  output q_status_t  stat
);

  entry_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.avail = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mte_back.sv =====
// Back end: shifts one symbol per transfer out of the current sequence and
// reloads from the queue without a bubble. Depends on mte_pkg, mte_if.
`default_nettype none

module mte_back import mte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_status_t  q_stat,
  input  entry_t     q_head,
  output logic       q_pop,
  mte_out_if.source  out_ch
);

  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             busy_r, busy_nxt;
  logic             out_xfer;
  logic             last_sym;

  assign last_sym        = (left_r == CNT_W'(1));
  assign out_ch.valid    = busy_r;
  assign out_ch.symbol   = seq_r[1:0];
  assign out_ch.run_last = last_sym;
  assign out_xfer        = out_ch.valid && out_ch.ready;

  // load when empty, or as the last symbol of the current run leaves
  assign q_pop = q_stat.avail && (!busy_r || (out_xfer && last_sym));

  always_comb begin
    seq_nxt  = seq_r;
    left_nxt = left_r;
    busy_nxt = busy_r;
    if (q_pop) begin
      seq_nxt  = q_head.seq;
      left_nxt = q_head.len;
      busy_nxt = 1'b1;
    end else if (out_xfer) begin
      seq_nxt  = seq_r >> 2;
      left_nxt = left_r - CNT_W'(1);
      busy_nxt = !last_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
  end

endmodule

`default_nettype wire
